/* hdl/gga_pkg.sv */
package gga_pkg;

   localparam int LINE_MAX           = 256;
   localparam int MINUTE_FRAC_DIGITS = 5;

   // line position counter, never holds more than LINE_MAX-1
   localparam int LEN_W = $clog2(LINE_MAX);
   // scaled minutes: two minute digits plus the fraction digits
   localparam int MS_W  = $clog2(10 ** (MINUTE_FRAC_DIGITS + 2));

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_A      = 8'h41;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_N      = 8'h4E;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_W      = 8'h57;

   localparam logic [3:0] FLD_LAT     = 4'd2;
   localparam logic [3:0] FLD_NS      = 4'd3;
   localparam logic [3:0] FLD_LON     = 4'd4;
   localparam logic [3:0] FLD_EW      = 4'd5;
   localparam logic [3:0] FLD_FIX     = 4'd6;
   localparam logic [3:0] FLD_SATS    = 4'd7;
   localparam logic [3:0] FLD_ALT     = 4'd9;
   localparam logic [3:0] FLD_MAX     = 4'd15;

   localparam logic [2:0] HDR_DONE     = 3'd6;
   localparam logic [2:0] HDR_MISMATCH = 3'd7;

   localparam logic [3:0] ALT_START = 4'd0;
   localparam logic [3:0] ALT_POS   = 4'd1;
   localparam logic [3:0] ALT_NEG   = 4'd2;
   localparam logic [3:0] ALT_DONE  = 4'd3;

   localparam logic [1:0] FIX_INVALID = 2'd3;

   localparam logic [7:0] ERR_MAX         = 8'hFF;
   localparam logic [7:0] ERR_LIMIT_RESET = 8'd10;

   localparam logic signed [21:0] ALT_HIGH = 22'sd99999;
   localparam logic signed [21:0] ALT_LOW  = -22'sd9999;

   localparam logic [32:0] LAT_LIMIT = 33'd900000000;
   localparam logic [32:0] LON_LIMIT = 33'd1800000000;
   localparam logic [23:0] E7        = 24'd10000000;

   // minutes/60 in 1e-7 degree = ms * 10^(6-F) / 6, done as one
   // multiplication by a rounded-up reciprocal and a shift
   localparam int              DIV6_K  = 30;
   localparam longint unsigned DIV6_M  = ((64'd1 << DIV6_K) + 64'd5) / 64'd6;
   localparam longint unsigned MS_MULT = (10 ** (6 - MINUTE_FRAC_DIGITS)) * DIV6_M;
   localparam int              MULT_W  = $clog2(MS_MULT + 1);
   localparam int              PROD_W  = MS_W + MULT_W;
   localparam int              Q_W     = 25;

   typedef struct packed {
      logic [6:0]         lat_deg;
      logic [MS_W-1:0]    lat_ms;
      logic               lat_south;
      logic [7:0]         lon_deg;
      logic [MS_W-1:0]    lon_ms;
      logic               lon_west;
      logic [1:0]         fix;
      logic [6:0]         sats;
      logic signed [17:0] alt;
      logic               found;
      logic               reset_req;
   } fix_snap_type;

   function automatic logic [MS_W-1:0] pow10(input logic [2:0] e);
      logic [MS_W-1:0] r;
      case (e)
         3'd0:    r = MS_W'(1);
         3'd1:    r = MS_W'(10);
         3'd2:    r = MS_W'(100);
         3'd3:    r = MS_W'(1000);
         3'd4:    r = MS_W'(10000);
         3'd5:    r = MS_W'(100000);
         3'd6:    r = MS_W'(1000000);
         default: r = MS_W'(10000000);
      endcase
      return r;
   endfunction

endpackage

/* hdl/gga_ifs.sv */
interface gga_req_if;
   import gga_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gga_rsp_if;
   import gga_pkg::*;
   logic               valid;
   logic               ready;
   logic signed [30:0] latitude_e7;
   logic signed [31:0] longitude_e7;
   logic [1:0]         fix_quality;
   logic [6:0]         satellites;
   logic signed [17:0] altitude_m;
   logic               fix_field_found;
   logic               reset_request;
   modport source (output valid, output latitude_e7, output longitude_e7,
                   output fix_quality, output satellites, output altitude_m,
                   output fix_field_found, output reset_request, input ready);
   modport sink   (input valid, input latitude_e7, input longitude_e7,
                   input fix_quality, input satellites, input altitude_m,
                   input fix_field_found, input reset_request, output ready);
endinterface

interface gga_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] error_limit;
   modport source (output valid, output error_limit, input ready);
   modport sink   (input valid, input error_limit, output ready);
endinterface

/* hdl/nmea_gga_sentence_parser.sv */
// A '\n' byte that ends a matching line yields its result through the
// parse/snapshot, multiply and output registers that lie behind the byte register.
// Throughput: one byte per cycle; results stall the byte path only when
// the result pipeline is full and the line end must hand over a result.
// Reset (synchronous, active high) clears line state and the error count,
// sets error_limit to 10 and empties every pipeline stage.
module nmea_gga_sentence_parser
   import gga_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gga_req_if.sink    req_bus,
   gga_rsp_if.source  rsp_bus,
   gga_csr_if.sink    csr_bus
);

   logic [7:0]   error_limit_ff;
   logic         snap_valid, snap_ready;
   fix_snap_type snap;

   // the limit register takes a write beat at any time
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         error_limit_ff <= ERR_LIMIT_RESET;
      else if (csr_bus.valid)
         error_limit_ff <= csr_bus.error_limit;
   end

   // byte register and line state: assemble fields, hand over a snapshot at the CR LF end of a matching line
   gga_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .error_limit (error_limit_ff),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap        (snap)
   );

   // fixed-point conversion and output register
   gga_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* hdl/gga_parse.sv */
module gga_parse
   import gga_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   gga_req_if.sink      req_bus,
   input  logic [7:0]   error_limit,
   output logic         snap_valid,
   input  logic         snap_ready,
   output fix_snap_type snap
);

   logic               byte_valid_ff, byte_valid_in;
   logic [7:0]         byte_ff;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [3:0]         fld_ff, fld_in;
   logic [2:0]         hdr_ff, hdr_in;
   logic               cr_ff, cr_in;
   logic [3:0]         dp_ff, dp_in;
   logic [6:0]         lat_deg_ff, lat_deg_in;
   logic [MS_W-1:0]    lat_ms_ff, lat_ms_in;
   logic               lat_s_ff, lat_s_in;
   logic [7:0]         lon_deg_ff, lon_deg_in;
   logic [MS_W-1:0]    lon_ms_ff, lon_ms_in;
   logic               lon_w_ff, lon_w_in;
   logic [1:0]         fix_ff, fix_in;
   logic [6:0]         sats_ff, sats_in;
   logic [3:0]         ones_ff, ones_in;
   logic signed [17:0] alt_ff, alt_in;
   logic [7:0]         err_ff, err_in;
   logic               snap_valid_ff, snap_valid_in;
   fix_snap_type       snap_ff, snap_in;

   logic               emit, go, is_digit, hdr_ok, found;
   logic [7:0]         ch;
   logic [3:0]         d;
   logic [10:0]        lat_v;
   logic [11:0]        lon_v;
   logic signed [21:0] alt_v;
   logic [7:0]         err_next;

   function automatic logic [MS_W-1:0] ms_add(input logic [3:0] p,
                                              input logic [3:0] dd,
                                              input logic [3:0] dig);
      logic [MS_W-1:0] r;
      logic [3:0]      f;
      r = '0;
      f = p - dd - 4'd2;
      if (p == dd)
         r = MS_W'(dig) * pow10(3'(MINUTE_FRAC_DIGITS + 1));
      else if (p == dd + 4'd1)
         r = MS_W'(dig) * pow10(3'(MINUTE_FRAC_DIGITS));
      else if (p > dd + 4'd2 && f <= 4'(MINUTE_FRAC_DIGITS))
         r = MS_W'(dig) * pow10(3'(4'(MINUTE_FRAC_DIGITS) - f));
      return r;
   endfunction

   assign ch       = byte_ff;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign d        = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
   assign emit     = byte_valid_ff && (ch == CH_LF) && (hdr_ff == HDR_DONE) && cr_ff;
   assign go       = byte_valid_ff && (!emit || !snap_valid_ff || snap_ready);
   assign found    = fld_ff >= FLD_FIX;
   assign err_next = (err_ff == ERR_MAX) ? err_ff : err_ff + 8'd1;

   assign req_bus.ready = !byte_valid_ff || go;
   assign snap_valid    = snap_valid_ff;
   assign snap          = snap_ff;

   always_comb begin
      case (len_ff[2:0])
         3'd0:    hdr_ok = ch == CH_DOLLAR;
         3'd1:    hdr_ok = ch == CH_G;
         3'd2:    hdr_ok = (ch == CH_P) || (ch == CH_N);
         3'd3:    hdr_ok = ch == CH_G;
         3'd4:    hdr_ok = ch == CH_G;
         default: hdr_ok = ch == CH_A;
      endcase
   end

   always_comb begin
      byte_valid_in = byte_valid_ff;
      len_in     = len_ff;
      fld_in     = fld_ff;
      hdr_in     = hdr_ff;
      cr_in      = cr_ff;
      dp_in      = dp_ff;
      lat_deg_in = lat_deg_ff;
      lat_ms_in  = lat_ms_ff;
      lat_s_in   = lat_s_ff;
      lon_deg_in = lon_deg_ff;
      lon_ms_in  = lon_ms_ff;
      lon_w_in   = lon_w_ff;
      fix_in     = fix_ff;
      sats_in    = sats_ff;
      ones_in    = ones_ff;
      alt_in     = alt_ff;
      err_in     = err_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;
      snap_in    = snap_ff;
      lat_v = 11'(lat_deg_ff) * 11'd10 + 11'(d);
      lon_v = 12'(lon_deg_ff) * 12'd10 + 12'(d);
      alt_v = 22'(alt_ff) * 22'sd10;

      if (go)
         byte_valid_in = 1'b0;
      if (req_bus.valid && req_bus.ready)
         byte_valid_in = 1'b1;

      if (go) begin
         if (ch == CH_LF || len_ff >= LEN_W'(LINE_MAX - 1)) begin
            if (emit) begin
               snap_valid_in     = 1'b1;
               snap_in.lat_deg   = lat_deg_ff;
               snap_in.lat_ms    = lat_ms_ff;
               snap_in.lat_south = lat_s_ff;
               snap_in.lon_deg   = lon_deg_ff;
               snap_in.lon_ms    = lon_ms_ff;
               snap_in.lon_west  = lon_w_ff;
               snap_in.fix       = found ? fix_ff : FIX_INVALID;
               snap_in.sats      = sats_ff;
               snap_in.alt       = alt_ff;
               snap_in.found     = found;
               snap_in.reset_req = !found && (err_next > error_limit);
               if (found) begin
                  if (fix_ff != FIX_INVALID)
                     err_in = '0;
               end else begin
                  err_in = err_next;
               end
            end
            // start the next line afresh
            len_in = '0; fld_in = '0; hdr_in = '0; cr_in = 1'b0; dp_in = '0;
            lat_deg_in = '0; lat_ms_in = '0; lat_s_in = 1'b0;
            lon_deg_in = '0; lon_ms_in = '0; lon_w_in = 1'b0;
            fix_in = FIX_INVALID; sats_in = '0; ones_in = '0; alt_in = '0;
         end else begin
            if (len_ff < LEN_W'(6)) begin
               hdr_in = (hdr_ff == len_ff[2:0] && hdr_ok) ? len_ff[2:0] + 3'd1
                                                          : HDR_MISMATCH;
            end else if (hdr_ff == HDR_DONE && ch != CH_CR) begin
               if (ch == CH_COMMA) begin
                  if (fld_ff < FLD_MAX)
                     fld_in = fld_ff + 4'd1;
                  dp_in = '0;
               end else if (fld_ff == FLD_ALT) begin
                  case (dp_ff)
                     ALT_START: begin
                        if (ch == CH_MINUS)
                           dp_in = ALT_NEG;
                        else if (ch == CH_PLUS)
                           dp_in = ALT_POS;
                        else if (is_digit) begin
                           dp_in  = ALT_POS;
                           alt_in = 18'(d);
                        end else
                           dp_in = ALT_DONE;
                     end
                     ALT_POS: begin
                        if (!is_digit)
                           dp_in = ALT_DONE;
                        else if (alt_v + $signed(22'(d)) > ALT_HIGH)
                           alt_in = 18'(ALT_HIGH);
                        else
                           alt_in = 18'(alt_v + $signed(22'(d)));
                     end
                     ALT_NEG: begin
                        if (!is_digit)
                           dp_in = ALT_DONE;
                        else if (alt_v - $signed(22'(d)) < ALT_LOW)
                           alt_in = 18'(ALT_LOW);
                        else
                           alt_in = 18'(alt_v - $signed(22'(d)));
                     end
                     default: ;
                  endcase
               end else begin
                  case (fld_ff)
                     FLD_LAT: begin
                        if (dp_ff < 4'd2)
                           lat_deg_in = (lat_v > 11'd127) ? 7'd127 : lat_v[6:0];
                        lat_ms_in = lat_ms_ff + ms_add(dp_ff, 4'd2, d);
                     end
                     FLD_NS: lat_s_in = ch == CH_S;
                     FLD_LON: begin
                        if (dp_ff < 4'd3)
                           lon_deg_in = (lon_v > 12'd255) ? 8'd255 : lon_v[7:0];
                        lon_ms_in = lon_ms_ff + ms_add(dp_ff, 4'd3, d);
                     end
                     FLD_EW: lon_w_in = ch == CH_W;
                     FLD_FIX: begin
                        if (dp_ff == 4'd0)
                           fix_in = (ch >= CH_ZERO && ch <= CH_TWO) ? 2'(ch - CH_ZERO)
                                                                     : FIX_INVALID;
                     end
                     FLD_SATS: begin
                        if (is_digit) begin
                           sats_in = 7'(ones_ff) * 7'd10 + 7'(d);
                           ones_in = d;
                        end
                     end
                     default: ;
                  endcase
                  if (dp_ff < 4'd15)
                     dp_in = dp_ff + 4'd1;
               end
            end
            cr_in  = ch == CH_CR;
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         snap_valid_ff <= 1'b0;
         len_ff <= '0; fld_ff <= '0; hdr_ff <= '0; cr_ff <= 1'b0; dp_ff <= '0;
         lat_deg_ff <= '0; lat_ms_ff <= '0; lat_s_ff <= 1'b0;
         lon_deg_ff <= '0; lon_ms_ff <= '0; lon_w_ff <= 1'b0;
         fix_ff <= FIX_INVALID; sats_ff <= '0; ones_ff <= '0; alt_ff <= '0;
         err_ff <= '0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         snap_valid_ff <= snap_valid_in;
         len_ff <= len_in; fld_ff <= fld_in; hdr_ff <= hdr_in; cr_ff <= cr_in;
         dp_ff <= dp_in;
         lat_deg_ff <= lat_deg_in; lat_ms_ff <= lat_ms_in; lat_s_ff <= lat_s_in;
         lon_deg_ff <= lon_deg_in; lon_ms_ff <= lon_ms_in; lon_w_ff <= lon_w_in;
         fix_ff <= fix_in; sats_ff <= sats_in; ones_ff <= ones_in; alt_ff <= alt_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready)
         byte_ff <= req_bus.rx_byte;
      snap_ff <= snap_in;
   end

endmodule

/* hdl/gga_conv.sv */
module gga_conv
   import gga_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         snap_valid,
   output logic         snap_ready,
   input  fix_snap_type snap,
   gga_rsp_if.source    rsp_bus
);

   logic               prod_valid_ff;
   logic [30:0]        lat_degp_ff;
   logic [31:0]        lon_degp_ff;
   logic [Q_W-1:0]     lat_q_ff, lon_q_ff;
   fix_snap_type       prod_snap_ff;

   logic               out_valid_ff;
   logic signed [30:0] lat_out_ff;
   logic signed [31:0] lon_out_ff;
   logic [1:0]         fix_out_ff;
   logic [6:0]         sats_out_ff;
   logic signed [17:0] alt_out_ff;
   logic               found_out_ff, req_out_ff;

   logic               out_ready, prod_ready;
   logic [PROD_W-1:0]  lat_prod, lon_prod;
   logic [32:0]        lat_mag, lon_mag, lat_sat, lon_sat, lat_signed, lon_signed;

   assign out_ready  = !out_valid_ff || rsp_bus.ready;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign snap_ready = prod_ready;

   // multiply stage: degrees by 1e7, minutes by the reciprocal of 60
   assign lat_prod = PROD_W'(snap.lat_ms) * PROD_W'(MS_MULT);
   assign lon_prod = PROD_W'(snap.lon_ms) * PROD_W'(MS_MULT);

   // sum, clamp, apply hemisphere
   assign lat_mag    = 33'(lat_degp_ff) + 33'(lat_q_ff);
   assign lon_mag    = 33'(lon_degp_ff) + 33'(lon_q_ff);
   assign lat_sat    = (lat_mag > LAT_LIMIT) ? LAT_LIMIT : lat_mag;
   assign lon_sat    = (lon_mag > LON_LIMIT) ? LON_LIMIT : lon_mag;
   assign lat_signed = prod_snap_ff.lat_south ? -lat_sat : lat_sat;
   assign lon_signed = prod_snap_ff.lon_west  ? -lon_sat : lon_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready)
            prod_valid_ff <= snap_valid;
         if (out_ready)
            out_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && snap_valid) begin
         lat_degp_ff  <= 31'(snap.lat_deg) * 31'(E7);
         lon_degp_ff  <= 32'(snap.lon_deg) * 32'(E7);
         lat_q_ff     <= lat_prod[DIV6_K +: Q_W];
         lon_q_ff     <= lon_prod[DIV6_K +: Q_W];
         prod_snap_ff <= snap;
      end
      if (out_ready && prod_valid_ff) begin
         lat_out_ff   <= lat_signed[30:0];
         lon_out_ff   <= lon_signed[31:0];
         fix_out_ff   <= prod_snap_ff.fix;
         sats_out_ff  <= prod_snap_ff.sats;
         alt_out_ff   <= prod_snap_ff.alt;
         found_out_ff <= prod_snap_ff.found;
         req_out_ff   <= prod_snap_ff.reset_req;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.latitude_e7     = lat_out_ff;
   assign rsp_bus.longitude_e7    = lon_out_ff;
   assign rsp_bus.fix_quality     = fix_out_ff;
   assign rsp_bus.satellites      = sats_out_ff;
   assign rsp_bus.altitude_m      = alt_out_ff;
   assign rsp_bus.fix_field_found = found_out_ff;
   assign rsp_bus.reset_request   = req_out_ff;

endmodule
